// ----- rtl/sync_pattern_packet_deframer_defines.svh -----
// Assertion macros for the sync pattern packet deframer.
// No dependencies; the asserting module supplies aclk and aresetn in its scope.
`ifndef SYNC_PATTERN_PACKET_DEFRAMER_DEFINES_SVH
`define SYNC_PATTERN_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer next-cycle check failed");

`endif

// ----- rtl/spd_pkg.sv -----
// Package for the sync pattern packet deframer: sync bytes, window sizes, types.
// No dependencies.
package spd_pkg;

    localparam int WIN_DEPTH  = 5;   // held bytes
    localparam int VIEW_DEPTH = 6;   // held bytes plus the incoming one
    localparam int CNT_W      = 3;   // fill and view counts

    typedef logic [7:0]       byte_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Header: SYNC0 SYNC1 SYNC2 <any> SYNC4
    localparam byte_t SYNC0_BYTE = 8'h5A;
    localparam byte_t SYNC1_BYTE = 8'h79;
    localparam byte_t SYNC2_BYTE = 8'h02;
    localparam byte_t SYNC4_BYTE = 8'h04;
    localparam byte_t CLOSE_BYTE = 8'h5D;

    // One packet byte with its marks
    typedef struct packed {
        byte_t data;
        logic  first;
        logic  last;
    } res_t;

    function automatic logic header_match(byte_t b0, byte_t b1, byte_t b2, byte_t b4);
        return (b0 == SYNC0_BYTE) && (b1 == SYNC1_BYTE) &&
               (b2 == SYNC2_BYTE) && (b4 == SYNC4_BYTE);
    endfunction

endpackage

// ----- rtl/sync_pattern_packet_deframer.sv -----
// Channel   Dir  Word
// s_        in   tdata[7:0] data byte, tlast buffer end
// m_        out  tdata[7:0] packet byte, tlast packet last, tuser packet first / run last
//
// One byte is accepted per cycle while the window waits for more bytes and the
// pending byte is not held by a stalled output; each extra byte released from
// the window (closing byte check, buffer-end drain) takes one more window step,
// and a single window step is done per cycle unless the output holds it. Results
// leave via a pending register (resolves the run mark) and the output register.
// Reset is synchronous, active low; the window itself is not cleared.
// A stalled output holds the pending byte and, when needed, the input side.
//
// Depends on spd_pkg and sync_pattern_packet_deframer_defines.svh.
`include "sync_pattern_packet_deframer_defines.svh"

module sync_pattern_packet_deframer
    import spd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // buffer_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] packet_byte
    output logic       m_tlast,    // packet_last
    output logic [1:0] m_tuser     // [0] packet_first, [1] run_last
);

    // Window step outcomes
    localparam logic [1:0] STEP_BRK   = 2'd0;
    localparam logic [1:0] STEP_DROP  = 2'd1;
    localparam logic [1:0] STEP_FLUSH = 2'd2;
    localparam logic [1:0] STEP_EMIT  = 2'd3;

    byte_t win_reg [WIN_DEPTH];
    cnt_t  fill_reg;
    logic  inside_reg;
    logic  at_end_reg;
    logic  pend_valid_reg;
    res_t  pend_reg;
    logic  out_valid_reg;
    res_t  out_reg;
    logic  out_run_last_reg;

    byte_t      view [VIEW_DEPTH];
    cnt_t       vcount;
    logic       view_end;
    logic       wait_st;
    logic       out_free;
    logic       s_accept;
    logic       active;
    logic [1:0] kind;
    logic       emit_first;
    logic       emit_last;
    logic       hdr0;
    logic       hdr1;
    logic       emit;
    logic       move;
    logic       hold;
    logic       go;

    // Current word done: window waits for more bytes
    assign wait_st = (fill_reg == '0) ||
                     (!inside_reg && (fill_reg < cnt_t'(WIN_DEPTH)) && !at_end_reg) ||
                     (inside_reg && (win_reg[0] == CLOSE_BYTE) && !at_end_reg);

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = wait_st && !(pend_valid_reg && !out_free);
    assign s_accept = s_tvalid && s_tready;

    // Working view: held bytes, plus the new word when one is taken
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            view[i] = win_reg[i];
        end
        view[VIEW_DEPTH-1] = '0;
        if (wait_st) begin
            view[fill_reg] = s_tdata;
        end
    end

    assign vcount   = wait_st ? (fill_reg + cnt_t'(s_accept)) : fill_reg;
    assign view_end = wait_st ? s_tlast : at_end_reg;
    assign active   = !wait_st || s_accept;

    assign hdr0 = header_match(view[0], view[1], view[2], view[4]);
    assign hdr1 = header_match(view[1], view[2], view[3], view[5]);

    // One step at the head of the view
    always_comb begin
        kind       = STEP_BRK;
        emit_first = 1'b0;
        emit_last  = 1'b0;
        if (vcount == '0) begin
            kind = STEP_BRK;
        end else if (!inside_reg) begin
            if (vcount >= cnt_t'(WIN_DEPTH)) begin
                kind       = hdr0 ? STEP_EMIT : STEP_DROP;
                emit_first = hdr0;
            end else begin
                kind = view_end ? STEP_FLUSH : STEP_BRK;
            end
        end else begin
            if ((view[0] == CLOSE_BYTE) && (vcount == cnt_t'(VIEW_DEPTH))) begin
                kind      = STEP_EMIT;
                emit_last = hdr1;
            end else if ((view[0] != CLOSE_BYTE) || view_end) begin
                kind      = STEP_EMIT;
                emit_last = view_end && (vcount == cnt_t'(1));
            end else begin
                kind = STEP_BRK;
            end
        end
    end

    // Pending byte leaves when a new one arrives or its word is done
    assign emit = active && (kind == STEP_EMIT);
    assign move = pend_valid_reg && (wait_st || emit);
    assign hold = move && !out_free;
    assign go   = active && !hold;

    // Window payload
    always_ff @(posedge aclk) begin
        if (go) begin
            case (kind)
                STEP_BRK: begin
                    for (int i = 0; i < WIN_DEPTH; i++) begin
                        win_reg[i] <= view[i];
                    end
                end
                STEP_DROP, STEP_EMIT: begin
                    for (int i = 0; i < WIN_DEPTH; i++) begin
                        win_reg[i] <= view[i+1];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Window control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            inside_reg <= 1'b0;
            at_end_reg <= 1'b0;
        end else if (go) begin
            at_end_reg <= view_end;
            case (kind)
                STEP_BRK:              fill_reg <= vcount;
                STEP_DROP, STEP_EMIT:  fill_reg <= vcount - cnt_t'(1);
                default:               fill_reg <= '0;
            endcase
            if (emit && emit_first) begin
                inside_reg <= 1'b1;
            end else if (emit && emit_last) begin
                inside_reg <= 1'b0;
            end
        end
    end

    // Pending and output payload
    always_ff @(posedge aclk) begin
        if (go && emit) begin
            pend_reg <= '{data: view[0], first: emit_first, last: emit_last};
        end
        if (move && !hold) begin
            out_reg          <= pend_reg;
            out_run_last_reg <= wait_st;
        end
    end

    // Pending and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (go && emit) begin
                pend_valid_reg <= 1'b1;
            end else if (move && !hold) begin
                pend_valid_reg <= 1'b0;
            end
            if (move && !hold) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = {out_run_last_reg, out_reg.first};

    // Checks
    `SPD_ASSERT_NOW(a_end_leaves_idle, wait_st && at_end_reg, (fill_reg == '0) && !inside_reg)
    `SPD_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= cnt_t'(WIN_DEPTH))
    `SPD_ASSERT_NEXT(a_pend_flush, wait_st && !s_accept && pend_valid_reg && out_free, !pend_valid_reg)
    `SPD_ASSERT_NEXT(a_pend_refill, go && emit && pend_valid_reg && !wait_st, pend_valid_reg)

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for sync_pattern_packet_deframer: directed and random byte buffers.
// Keeps its own window predictor and checks every packet word in order.
// Depends on spd_pkg and the deframer RTL.
module testbench;
    import spd_pkg::*;

    // One expected packet word with its marks
    typedef struct {
        byte_t data;
        bit    first;
        bit    last;
        bit    run_end;
    } pkt_word_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // [7:0] data byte
    logic       s_tlast;     // buffer end
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // [7:0] packet byte
    logic       m_tlast;     // packet last
    logic [1:0] m_tuser;     // [0] packet first, [1] run last

    // Predictor state: held bytes, their count, packet-open flag
    byte_t     held_bytes[WIN_DEPTH];
    int        held_count;
    bit        pkt_open;
    pkt_word_t pkt_expect[$];

    int        mismatches;
    int        items_sent;
    bit        gaps_on;
    bit        stalls_on;
    int        stall_left;

    sync_pattern_packet_deframer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Header test at offset k of the view
    function automatic bit sync_at(byte_t v[VIEW_DEPTH], int k);
        return v[k] == SYNC0_BYTE && v[k+1] == SYNC1_BYTE &&
               v[k+2] == SYNC2_BYTE && v[k+4] == SYNC4_BYTE;
    endfunction

    // Advance the predictor by one accepted byte and queue the words it releases
    function automatic void deframe_byte(byte_t b, bit at_end);
        byte_t     view[VIEW_DEPTH];
        pkt_word_t run_q[$];
        pkt_word_t w;
        int        n;
        int        head;
        int        avail;
        bit        closes;
        n = held_count;
        for (int i = 0; i < n; i++)
            view[i] = held_bytes[i];
        view[n] = b;
        n++;
        head = 0;
        while (head < n) begin
            avail = n - head;
            if (!pkt_open) begin
                if (avail >= 5) begin
                    if (sync_at(view, head)) begin
                        pkt_open = 1'b1;
                        w = '{data: view[head], first: 1'b1, last: 1'b0, run_end: 1'b0};
                        run_q.push_back(w);
                    end
                    head++;
                end else if (at_end) begin
                    head = n;
                end else begin
                    break;
                end
            end else begin
                // closing byte needs a full header after it, unless the buffer ends
                if (view[head] == CLOSE_BYTE && avail >= 6)
                    closes = sync_at(view, head + 1);
                else if (view[head] != CLOSE_BYTE || at_end)
                    closes = at_end && avail == 1;
                else
                    break;
                w = '{data: view[head], first: 1'b0, last: closes, run_end: 1'b0};
                run_q.push_back(w);
                if (closes)
                    pkt_open = 1'b0;
                head++;
            end
        end
        held_count = n - head;
        for (int i = 0; i < held_count; i++)
            held_bytes[i] = view[head + i];
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].run_end = 1'b1;
        foreach (run_q[i])
            pkt_expect.push_back(run_q[i]);
    endfunction

    // Output stalls, driven at the falling edge
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (!stalls_on || stall_left == 0) begin
                m_tready <= 1'b1;
                if (stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_len();
            end else begin
                m_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Packet word checker
    always @(posedge aclk) begin
        pkt_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pkt_expect.size() == 0) begin
                $display("%0t unexpected word: data %h first %b last %b run %b",
                         $time, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
                mismatches++;
            end else begin
                w = pkt_expect.pop_front();
                if (m_tdata !== w.data || m_tuser[0] !== w.first ||
                    m_tlast !== w.last || m_tuser[1] !== w.run_end) begin
                    // data, first, last, run mark
                    $display("%0t mismatch: expected %h f%b l%b r%b, got %h f%b l%b r%b",
                             $time, w.data, w.first, w.last, w.run_end,
                             m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    // Send one byte with an optional random gap before it
    task automatic send_byte(input byte_t b, input bit at_end);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0)
            gap = pick_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= at_end;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(b, at_end);
        items_sent++;
    endtask

    task automatic send_frame(input byte_t frame_q[$]);
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic go_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Wait for every expected word, then wait on for stragglers
    task automatic wait_drained();
        while (pkt_expect.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Byte that is often one of the sync or closing values
    function automatic byte_t pick_byte();
        case ($urandom_range(0, 9))
            0: return SYNC0_BYTE;
            1: return SYNC1_BYTE;
            2: return SYNC2_BYTE;
            3: return SYNC4_BYTE;
            4: return CLOSE_BYTE;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Build one random buffer: mostly well-formed packets, some noise or broken headers
    function automatic void make_buffer(ref byte_t frame_q[$]);
        int kind;
        int npk;
        frame_q = {};
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            repeat ($urandom_range(0, 2)) frame_q.push_back(pick_byte());
            npk = $urandom_range(1, 3);
            for (int p = 0; p < npk; p++) begin
                frame_q.push_back(SYNC0_BYTE);
                frame_q.push_back(SYNC1_BYTE);
                frame_q.push_back(SYNC2_BYTE);
                frame_q.push_back(byte_t'($urandom_range(0, 255)));
                frame_q.push_back(SYNC4_BYTE);
                repeat ($urandom_range(0, 6)) frame_q.push_back(pick_byte());
                if (p < npk - 1)
                    frame_q.push_back(CLOSE_BYTE);
            end
            case ($urandom_range(0, 2))
                0: frame_q.push_back(CLOSE_BYTE);
                1: begin
                    frame_q.push_back(SYNC0_BYTE);
                    frame_q.push_back(SYNC1_BYTE);
                    frame_q.push_back(SYNC2_BYTE);
                end
                default: ;
            endcase
        end else if (kind < 9) begin
            repeat ($urandom_range(1, 8)) frame_q.push_back(pick_byte());
        end else begin
            // header with a wrong fifth byte
            frame_q.push_back(SYNC0_BYTE);
            frame_q.push_back(SYNC1_BYTE);
            frame_q.push_back(SYNC2_BYTE);
            frame_q.push_back(byte_t'($urandom_range(0, 255)));
            frame_q.push_back(byte_t'($urandom_range(5, 255)));
            repeat ($urandom_range(0, 5)) frame_q.push_back(pick_byte());
        end
    endfunction

    // Header extremes and the close-by-header rule with the header ending the buffer
    task automatic test_close_by_header();
        send_frame('{SYNC0_BYTE, SYNC1_BYTE, SYNC2_BYTE, 8'h00, SYNC4_BYTE, CLOSE_BYTE,
                     SYNC0_BYTE, SYNC1_BYTE, SYNC2_BYTE, 8'hFF, SYNC4_BYTE});
    endtask

    // Closing byte too near the buffer end, then a closing byte as the final byte
    task automatic test_close_near_end();
        send_frame('{SYNC0_BYTE, SYNC1_BYTE, SYNC2_BYTE, 8'h7F, SYNC4_BYTE, CLOSE_BYTE,
                     SYNC0_BYTE, SYNC1_BYTE, SYNC2_BYTE, 8'h80, SYNC4_BYTE, CLOSE_BYTE,
                     8'h01, CLOSE_BYTE});
    endtask

    // Header cut short by the buffer end: all dropped
    task automatic test_cut_header();
        send_frame('{SYNC0_BYTE, SYNC1_BYTE, SYNC2_BYTE, 8'hA5});
    endtask

    // Random buffers; the first stretch runs with no gaps or stalls
    task automatic test_random_buffers(input int target);
        byte_t frame_q[$];
        while (items_sent < target) begin
            if (items_sent > 80) begin
                gaps_on   = 1'b1;
                stalls_on = 1'b1;
            end
            make_buffer(frame_q);
            send_frame(frame_q);
        end
    endtask

    // Sender holds off mid-buffer until every expected word has come out
    task automatic test_drain_pause();
        byte_t frame_q[$];
        repeat (2) begin
            make_buffer(frame_q);
            foreach (frame_q[i]) begin
                send_byte(frame_q[i], i == frame_q.size() - 1);
                if (i == frame_q.size() / 2) begin
                    go_idle();
                    wait_drained();
                end
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        held_count = 0;
        pkt_open   = 1'b0;
        mismatches = 0;
        items_sent = 0;
        gaps_on    = 1'b0;
        stalls_on  = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_close_by_header();
        test_close_near_end();
        test_cut_header();
        test_random_buffers(140);
        test_drain_pause();
        test_random_buffers(210);

        go_idle();
        wait_drained();
        if (mismatches == 0 && pkt_expect.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
